// ===== design/cbb_pkg.sv =====
// Shared constants, codes and types for the circular byte buffer.
// No dependencies; every other file but cbb_ram imports this package.
package cbb_pkg;

    localparam int DEPTH = 4096;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int DW    = 8;
    localparam int FW    = 3;

    typedef enum logic [FW-1:0] {
        FN_PUSH    = 3'd0,
        FN_POP     = 3'd1,
        FN_DISCARD = 3'd2,
        FN_COMMIT  = 3'd3,
        FN_CLEAR   = 3'd4
    } t_func;

    // controller -> datapath
    typedef struct packed {
        logic take;     // beat accepted on the input channel this cycle
    } t_dp_cmd;

    // datapath result, held until the output beat is taken
    typedef struct packed {
        logic [DW-1:0] read_byte;
        logic          accepted;
        logic [CW-1:0] fill_count;
        logic [AW-1:0] read_index;
        logic [AW-1:0] write_index;
        logic [CW-1:0] used_span;
        logic [CW-1:0] free_span;
    } t_result;

endpackage

// ===== design/cbb_if.sv =====
// Valid/ready channel interfaces for the circular byte buffer.
// Depends on cbb_pkg for field widths.
interface cbb_item_if import cbb_pkg::*;;
    logic          valid;
    logic          ready;
    logic [FW-1:0] func;
    logic [DW-1:0] data_byte;
    logic [CW-1:0] count;

    modport source (output valid, func, data_byte, count, input ready);
    modport sink   (input valid, func, data_byte, count, output ready);
endinterface

interface cbb_result_if import cbb_pkg::*;;
    logic          valid;
    logic          ready;
    logic [DW-1:0] read_byte;
    logic          accepted;
    logic [CW-1:0] fill_count;
    logic [AW-1:0] read_index;
    logic [AW-1:0] write_index;
    logic [CW-1:0] used_span;
    logic [CW-1:0] free_span;

    modport source (output valid, read_byte, accepted, fill_count, read_index,
                    write_index, used_span, free_span, input ready);
    modport sink   (input valid, read_byte, accepted, fill_count, read_index,
                    write_index, used_span, free_span, output ready);
endinterface

// ===== design/cbb_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/cbb_ctrl.sv =====
// Handshake controller for the circular byte buffer: take a beat, present result.
// Depends on cbb_pkg.
module cbb_ctrl import cbb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RESP = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_RESP);
    assign o_cmd.take  = (r_state == S_IDLE) && i_in_valid;
endmodule

// ===== design/cbb_datapath.sv =====
// Pointer/count datapath and byte store of the circular byte buffer.
// Depends on cbb_pkg and cbb_ram.
module cbb_datapath import cbb_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_dp_cmd       i_cmd,
    input  logic [FW-1:0] i_func,
    input  logic [DW-1:0] i_data_byte,
    input  logic [CW-1:0] i_count,
    output t_result       o_res
);
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_fill, n_fill;
    logic          r_ok, n_ok;
    logic          r_pop, n_pop;
    logic [CW-1:0] room;
    logic          ram_we;
    logic          ram_re;
    logic [DW-1:0] ram_rdata;
    logic [CW-1:0] head_gap;
    logic [CW-1:0] tail_gap;
    logic [CW-1:0] free_cnt;

    // pointer + n, wrapped once at DEPTH
    function automatic logic [AW-1:0] adv(input logic [AW-1:0] ptr,
                                          input logic [CW-1:0] n);
        logic [CW:0] s;
        s = (CW+1)'(ptr) + (CW+1)'(n);
        if (s >= (CW+1)'(DEPTH)) begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign room = CW'(DEPTH) - r_fill;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        n_ok   = 1'b0;
        n_pop  = 1'b0;
        ram_we = 1'b0;
        ram_re = 1'b0;
        unique case (t_func'(i_func))
            FN_PUSH: begin
                if (room != '0) begin
                    ram_we = i_cmd.take;
                    n_tail = adv(r_tail, CW'(1));
                    n_fill = r_fill + CW'(1);
                    n_ok   = 1'b1;
                end
            end
            FN_POP: begin
                if (r_fill != '0) begin
                    ram_re = i_cmd.take;
                    n_head = adv(r_head, CW'(1));
                    n_fill = r_fill - CW'(1);
                    n_ok   = 1'b1;
                    n_pop  = 1'b1;
                end
            end
            FN_DISCARD: begin
                if (i_count <= r_fill) begin
                    n_head = adv(r_head, i_count);
                    n_fill = r_fill - i_count;
                    n_ok   = 1'b1;
                end
            end
            FN_COMMIT: begin
                if (i_count <= room) begin
                    n_tail = adv(r_tail, i_count);
                    n_fill = r_fill + i_count;
                    n_ok   = 1'b1;
                end
            end
            FN_CLEAR: begin
                n_head = '0;
                n_tail = '0;
                n_fill = '0;
                n_ok   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
            r_ok   <= 1'b0;
            r_pop  <= 1'b0;
        end else if (i_cmd.take) begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
            r_ok   <= n_ok;
            r_pop  <= n_pop;
        end
    end

    cbb_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (i_data_byte),
        .i_re    (ram_re),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    // spans to the wrap point, from the updated state
    assign head_gap = CW'(DEPTH) - CW'(r_head);
    assign tail_gap = CW'(DEPTH) - CW'(r_tail);
    assign free_cnt = CW'(DEPTH) - r_fill;

    assign o_res.read_byte   = r_pop ? ram_rdata : '0;
    assign o_res.accepted    = r_ok;
    assign o_res.fill_count  = r_fill;
    assign o_res.read_index  = r_head;
    assign o_res.write_index = r_tail;
    assign o_res.used_span   = (r_fill < head_gap) ? r_fill : head_gap;
    assign o_res.free_span   = (free_cnt < tail_gap) ? free_cnt : tail_gap;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(DEPTH))
        else $error("fill count above depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0) |-> (r_head == r_tail))
        else $error("empty store with pointers apart");

    a_refused_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take ##1 !r_ok |-> (r_fill == $past(r_fill)) &&
                                 (r_head == $past(r_head)) &&
                                 (r_tail == $past(r_tail)))
        else $error("refused operation changed state");
endmodule

// ===== design/circular_byte_buffer_core.sv =====
// Circular byte buffer: top level joining controller and datapath.
// Depends on cbb_pkg, cbb_if, cbb_ctrl, cbb_datapath (and cbb_ram below it).
//
// Usage:
//   i_item carries one operation per beat: push a byte, pop a byte, discard
//   or commit a byte count, or clear. o_result returns exactly one beat per
//   operation with the popped byte, accept flag, fill count, both pointers
//   and the contiguous used and free spans up to the wrap point.
//   The result is valid on the cycle after the input beat is taken.
//   No new operation is taken until the result of the last is delivered.
//   The byte store is a single RAM with a registered read port; a pop reads
//   at the head pointer in the accept cycle and the data is shown from the
//   RAM output register in the cycle after. The controller keeps the input
//   closed while a result beat is held.
//   Refused operations (full push, empty pop, oversized discard or commit,
//   unknown code) return accepted = 0 and leave all state unchanged.
//   Reset (synchronous, active low) zeroes both pointers and the fill count;
//   the store contents are not cleared, and clear does not touch them either.
//   When the receiver stalls the result beat is held and no new input is
//   taken until it has been delivered.
module circular_byte_buffer_core import cbb_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cbb_item_if.sink      i_item,
    cbb_result_if.source  o_result
);
    t_dp_cmd cmd;
    t_result res;

    cbb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_out_ready (o_result.ready),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .o_cmd       (cmd)
    );

    cbb_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_func      (i_item.func),
        .i_data_byte (i_item.data_byte),
        .i_count     (i_item.count),
        .o_res       (res)
    );

    assign o_result.read_byte   = res.read_byte;
    assign o_result.accepted    = res.accepted;
    assign o_result.fill_count  = res.fill_count;
    assign o_result.read_index  = res.read_index;
    assign o_result.write_index = res.write_index;
    assign o_result.used_span   = res.used_span;
    assign o_result.free_span   = res.free_span;

    // every accepted beat is answered on the next cycle, input closed meanwhile
    a_take_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> (o_result.valid && !i_item.ready))
        else $error("accepted beat not answered");
endmodule

// ===== dv/cbb_status_checker.sv =====
// Scoreboard for the circular byte buffer: mirrors pointers, fill count and
// byte contents, predicts the status beat of every operation and compares in order.
// Depends on cbb_pkg and the channel interfaces in cbb_if.
module cbb_status_checker import cbb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    cbb_item_if   item_ch,
    cbb_result_if res_ch,
    output int    o_errors,
    output int    o_pending,
    output int    o_fill,
    output bit    o_pop_safe
);

    logic [DW-1:0] bytes_held [DEPTH];
    bit            written    [DEPTH];
    int            rd_ptr;
    int            wr_ptr;
    int            fill;
    t_result       status_due [$];

    function automatic int wrap_ptr(input int p);
        return (p >= DEPTH) ? p - DEPTH : p;
    endfunction

    // Apply one operation to the mirrored buffer and queue the status it returns.
    task automatic apply_op(input logic [FW-1:0] fn, input logic [DW-1:0] b,
                            input logic [CW-1:0] n);
        t_result st;
        int      room;
        st   = '0;
        room = DEPTH - fill;
        case (fn)
            FN_PUSH: if (room > 0) begin
                bytes_held[wr_ptr] = b;
                written[wr_ptr]    = 1'b1;
                wr_ptr             = wrap_ptr(wr_ptr + 1);
                fill++;
                st.accepted = 1'b1;
            end
            FN_POP: if (fill > 0) begin
                st.read_byte = written[rd_ptr] ? bytes_held[rd_ptr] : '0;
                rd_ptr       = wrap_ptr(rd_ptr + 1);
                fill--;
                st.accepted = 1'b1;
            end
            FN_DISCARD: if (int'(n) <= fill) begin
                rd_ptr = wrap_ptr(rd_ptr + int'(n));
                fill   = fill - int'(n);
                st.accepted = 1'b1;
            end
            FN_COMMIT: if (int'(n) <= room) begin
                wr_ptr = wrap_ptr(wr_ptr + int'(n));
                fill   = fill + int'(n);
                st.accepted = 1'b1;
            end
            FN_CLEAR: begin
                rd_ptr = 0;
                wr_ptr = 0;
                fill   = 0;
                st.accepted = 1'b1;
            end
            default: ;
        endcase
        room           = DEPTH - fill;
        st.fill_count  = CW'(fill);
        st.read_index  = AW'(rd_ptr);
        st.write_index = AW'(wr_ptr);
        st.used_span   = CW'((fill < DEPTH - rd_ptr) ? fill : DEPTH - rd_ptr);
        st.free_span   = CW'((room < DEPTH - wr_ptr) ? room : DEPTH - wr_ptr);
        status_due.push_back(st);
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] seen);
        if (seen !== want) begin
            $error("%s: expected %0d, got %0d", field, want, seen);
            o_errors++;
        end
    endtask

    // Sampled mid-cycle: inputs and outputs are settled, and a beat seen here
    // is taken at the next rising edge.
    always @(negedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            rd_ptr = 0;
            wr_ptr = 0;
            fill   = 0;
            status_due.delete();
        end else begin
            if (item_ch.valid && item_ch.ready)
                apply_op(item_ch.func, item_ch.data_byte, item_ch.count);
            if (res_ch.valid && res_ch.ready) begin
                if (status_due.size() == 0) begin
                    $error("status beat with no operation outstanding");
                    o_errors++;
                end else begin
                    want = status_due.pop_front();
                    check_field("read_byte",   16'(want.read_byte),
                                16'(res_ch.read_byte));
                    check_field("accepted",    16'(want.accepted),
                                16'(res_ch.accepted));
                    check_field("fill_count",  16'(want.fill_count),
                                16'(res_ch.fill_count));
                    check_field("read_index",  16'(want.read_index),
                                16'(res_ch.read_index));
                    check_field("write_index", 16'(want.write_index),
                                16'(res_ch.write_index));
                    check_field("used_span",   16'(want.used_span),
                                16'(res_ch.used_span));
                    check_field("free_span",   16'(want.free_span),
                                16'(res_ch.free_span));
                end
            end
        end
        o_pending  = status_due.size();
        o_fill     = fill;
        o_pop_safe = (fill == 0) || written[rd_ptr];
    end

endmodule

// ===== dv/circular_byte_buffer_core_test.sv =====
// Testbench top for circular_byte_buffer_core: drives operation beats in
// bursts, stalls the status channel, and reports the scoreboard verdict.
// Depends on cbb_pkg, cbb_if, cbb_status_checker and the block itself.
module circular_byte_buffer_core_test;
    import cbb_pkg::*;

    localparam int LONG_HOLD    = 300;     // receiver hold-off, in cycles
    localparam int RANDOM_OPS   = 650;     // valid-code operations in the random part
    localparam int HOLD_AT      = 200;
    localparam int DRAIN_AT     = 420;
    localparam int LIMIT_CYCLES = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int errors;
    int pending;
    int fill;
    bit pop_safe;
    bit hold_req;
    bit hold_done;
    int burst_left;

    cbb_item_if   item_ch ();
    cbb_result_if res_ch ();

    circular_byte_buffer_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (res_ch)
    );

    // Scoreboard sits beside the block; it also exposes the mirrored fill and
    // whether the head entry holds real data, which steers stimulus.
    cbb_status_checker u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .item_ch    (item_ch),
        .res_ch     (res_ch),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_fill     (fill),
        .o_pop_safe (pop_safe)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop in case the handshake hangs.
    initial begin
        #(LIMIT_CYCLES * 10);
        $display("== FAIL ==");
        $finish;
    end

    // Status-channel receiver. Stall pattern changes after each random run:
    // always ready, coin flip, mostly stalled, or alternating. One long
    // hold-off is taken when the stimulus asks for it.
    initial begin : receiver
        int mode;
        int mode_left;
        mode_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
                res_ch.ready <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= 1'($urandom_range(0, 1));
                    2:       res_ch.ready <= ($urandom_range(0, 7) == 0);
                    default: res_ch.ready <= ~res_ch.ready;
                endcase
            end
        end
    end

    // Offer one beat and hold it until taken. Ready is sampled at the falling
    // edge, where it is settled for the coming rising edge. After each burst
    // the sender may go quiet for a random gap.
    task automatic send_op(input logic [FW-1:0] fn, input logic [DW-1:0] b,
                           input logic [CW-1:0] n);
        bit took;
        int gap;
        item_ch.valid     <= 1'b1;
        item_ch.func      <= fn;
        item_ch.data_byte <= b;
        item_ch.count     <= n;
        do begin
            @(negedge i_clk);
            took = item_ch.ready;
            @(posedge i_clk);
        end while (!took);
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
    endtask

    initial begin : stimulus
        int            done_ops;
        int            pick;
        int            room;
        logic [FW-1:0] fn;
        logic [DW-1:0] b;
        logic [CW-1:0] n;

        i_rst_n           <= 1'b0;
        item_ch.valid     <= 1'b0;
        item_ch.func      <= FN_PUSH;
        item_ch.data_byte <= '0;
        item_ch.count     <= '0;
        burst_left = $urandom_range(1, 40);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed ---
        send_op(FN_POP,     8'h00, '0);               // pop from empty: refused
        send_op(FN_DISCARD, 8'h00, '0);               // zero-length discard
        send_op(FN_COMMIT,  8'h00, '0);               // zero-length commit
        send_op(FN_DISCARD, 8'h00, CW'(1));           // discard past fill: refused
        send_op(FN_PUSH,    8'h00, '0);
        send_op(FN_PUSH,    8'hFF, '0);
        send_op(FN_PUSH,    8'hA5, '0);
        send_op(FN_POP,     8'h00, '0);
        send_op(FN_POP,     8'h00, '0);
        send_op(FN_DISCARD, 8'h00, CW'(1));           // back to empty, pointers at 3
        send_op(FW'(FN_CLEAR + 1), 8'hFF, CW'(DEPTH)); // unused codes: ignored
        send_op(FW'((1 << FW) - 1), 8'h5A, CW'(1));
        send_op(FN_COMMIT,  8'h00, CW'(DEPTH));       // whole store, tail wraps
        send_op(FN_PUSH,    8'h5A, '0);               // push to full: refused
        send_op(FN_COMMIT,  8'h00, CW'(1));           // commit past free: refused
        send_op(FN_DISCARD, 8'h00, CW'(DEPTH));       // drop everything
        send_op(FN_CLEAR,   8'h00, '0);
        send_op(FN_COMMIT,  8'h00, CW'(DEPTH - 3));
        send_op(FN_PUSH,    8'h11, '0);               // last three slots, tail wraps to 0
        send_op(FN_PUSH,    8'h22, '0);
        send_op(FN_PUSH,    8'h33, '0);
        send_op(FN_DISCARD, 8'h00, CW'(DEPTH - 3));   // head lands at the top end
        send_op(FN_POP,     8'h00, '0);
        send_op(FN_POP,     8'h00, '0);               // head reaches the top slot
        send_op(FN_CLEAR,   8'h00, '0);               // clear with data still held

        // --- random ---
        done_ops = 0;
        while (done_ops < RANDOM_OPS) begin
            b    = DW'($urandom_range(0, 255));
            n    = CW'($urandom_range(0, DEPTH));
            pick = $urandom_range(0, 99);
            room = DEPTH - fill;
            if (pick < 38) begin
                fn = FN_PUSH;
            end else if (pick < 68) begin
                fn = FN_POP;
                // head entry only made valid by a commit holds no data: skip it
                if (!pop_safe) begin
                    fn = FN_DISCARD;
                    n  = CW'(1);
                end
            end else if (pick < 80) begin
                fn = FN_DISCARD;
                case ($urandom_range(0, 3))
                    0, 1: n = CW'($urandom_range(0, fill));
                    2:    n = CW'(fill);
                    default: begin
                        if (fill < DEPTH)
                            n = CW'($urandom_range(fill + 1, DEPTH));
                    end
                endcase
            end else if (pick < 92) begin
                fn = FN_COMMIT;
                case ($urandom_range(0, 3))
                    0: n = CW'($urandom_range(0, 16));
                    1: n = CW'(room);
                    2: begin
                        if (room < DEPTH)
                            n = CW'($urandom_range(room + 1, DEPTH));
                    end
                    default: n = CW'($urandom_range(0, room));
                endcase
            end else if (pick < 97) begin
                fn = FN_CLEAR;
            end else begin
                fn = FW'($urandom_range(FN_CLEAR + 1, (1 << FW) - 1));
            end

            send_op(fn, b, n);
            if (fn <= FN_CLEAR) begin
                done_ops++;
                // long receiver hold-off while beats keep coming: input backs up
                if (done_ops == HOLD_AT)
                    hold_req <= 1'b1;
                // sender goes quiet until every status beat is back
                if (done_ops == DRAIN_AT) begin
                    item_ch.valid <= 1'b0;
                    do @(posedge i_clk); while (pending != 0);
                end
            end
        end

        item_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
